// ===== rtl/stq_pkg.sv =====
package stq_pkg;
  localparam int MaxTimers = 16;
  localparam int IdxW = $clog2(MaxTimers);
  localparam int LenW = $clog2(MaxTimers + 1);
  localparam int RemW = 25;
  localparam int IdW = 4;
  localparam int EntW = IdW + RemW;
  localparam logic [RemW-1:0] RemMax = {RemW{1'b1}};
  localparam logic [14:0] UnsyncMax = 15'h7FFF;
  localparam logic [14:0] FlushReset = 15'd20000;
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CREATE = 1'b1;
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_SHIFT  = 7'b0000100,
    ST_FLUSH  = 7'b0001000,
    ST_HEAD   = 7'b0010000,
    ST_SYNC   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [RemW-1:0] rem;
  } entry_t;
endpackage

// ===== rtl/stq_ram.sv =====
module stq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sorted_software_timer_queue.sv =====
// Sorted timer queue.
// Input: pulse start with in_req_type, in_timer_id, in_delay while busy is low.
//   A tick (req_type 0) advances the tick counter; a create (req_type 1)
//   inserts a timer sorted by remaining ticks.
// Output: each result appears for one cycle with out_valid high; the receiver
//   cannot stall, so none is ever held. out_last marks the final result of a
//   request. Successful creates and ticks with nothing due give no result.
// Structure: the queue lives in one RAM with a registered read and one
//   write port, walked one entry per cycle. A create walks the queue in a
//   search pass then a shift pass; a flush and an expiring tick each walk it
//   once, while other ticks only read the head and a rejected create reads
//   nothing. A reject's result is registered at the accepting edge; a flush or
//   expiry result follows the read of its entry. cfg_we with cfg_wdata writes
// flush_limit; the user must do so only while the block is idle (unchecked).
// Reset (rst_n low, synchronous) empties the queue, clears counters and sets
//   flush_limit to 20000. No clearing pass is needed.
module sorted_software_timer_queue
  import stq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [3:0]  in_timer_id,
  input  logic [23:0] in_delay,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_kind,
  output logic [3:0]  out_expired_id,
  output logic        out_last,
  output logic [31:0] out_tick_count
);
  state_t state_r, state_nxt;
  logic [14:0] flush_r;
  logic [LenW-1:0] len_r, len_nxt;
  logic [14:0] uns_r, uns_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [LenW-1:0] ptr_r, ptr_nxt;
  logic [IdW-1:0] id_r, id_nxt;
  logic [RemW-1:0] rem_r, rem_nxt;
  logic rd_v_r, rd_v_nxt;
  entry_t hold_r, hold_nxt;
  logic ov_r, ov_nxt;
  logic okind_r, okind_nxt, olast_r, olast_nxt;
  logic [IdW-1:0] oid_r, oid_nxt;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [RemW-1:0] sum;
  logic [14:0] uinc;

  stq_ram #(.Width(EntW), .Depth(MaxTimers)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_expired_id = oid_r;
  assign out_last = olast_r;
  assign out_tick_count = tick_r;
  assign sum = RemW'(uns_r) + RemW'(in_delay);
  assign uinc = (uns_r < UnsyncMax) ? uns_r + 15'd1 : uns_r;

  always_comb begin
    state_nxt = state_r; len_nxt = len_r; uns_nxt = uns_r; tick_nxt = tick_r;
    ptr_nxt = ptr_r; id_nxt = id_r; rem_nxt = rem_r;
    rd_v_nxt = 1'b0; hold_nxt = hold_r; ov_nxt = 1'b0;
    okind_nxt = okind_r; olast_nxt = olast_r; oid_nxt = oid_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = ptr_r[IdxW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        ptr_nxt = '0;
        raddr = '0;
        if (start) begin
          id_nxt = in_timer_id;
          if (in_req_type == REQ_CREATE) begin
            if (len_r >= LenW'(MaxTimers)) begin
              ov_nxt = 1'b1; okind_nxt = KIND_REJECT; oid_nxt = in_timer_id;
              olast_nxt = 1'b1; state_nxt = ST_DONE;
            end else begin
              rem_nxt = sum;
              rd_v_nxt = (len_r != '0);
              ptr_nxt = '0;
              state_nxt = ST_SEARCH;
            end
          end else begin
            tick_nxt = tick_r + 32'd1;
            uns_nxt = uinc;
            rd_v_nxt = (len_r != '0);
            if (uinc >= flush_r) begin
              state_nxt = ST_FLUSH;
            end else begin
              state_nxt = ST_HEAD;
            end
          end
        end
      end
      ST_SEARCH: begin
        // rdata = entry ptr_r when rd_v_r
        if (rd_v_r && rdata.rem < rem_r) begin
          ptr_nxt = ptr_r + 1'b1;
          raddr = IdxW'(ptr_r + 1'b1);
          rd_v_nxt = (ptr_r + 1'b1 < len_r);
        end else begin
          hold_nxt = '{id: id_r, rem: rem_r};
          ptr_nxt = ptr_r;
          raddr = ptr_r[IdxW-1:0];
          rd_v_nxt = (ptr_r < len_r);
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // write held entry at ptr, carry old entry forward
        we = 1'b1; waddr = ptr_r[IdxW-1:0]; wdata = hold_r;
        hold_nxt = rdata;
        if (ptr_r == len_r) begin
          len_nxt = len_r + 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          raddr = IdxW'(ptr_r + 1'b1);
          rd_v_nxt = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!rd_v_r) begin
          len_nxt = '0; uns_nxt = '0; state_nxt = ST_DONE;
        end else begin
          ov_nxt = 1'b1; okind_nxt = KIND_EXPIRED; oid_nxt = rdata.id;
          olast_nxt = (ptr_r + 1'b1 == len_r);
          ptr_nxt = ptr_r + 1'b1;
          raddr = IdxW'(ptr_r + 1'b1);
          rd_v_nxt = (ptr_r + 1'b1 < len_r);
        end
      end
      ST_HEAD: begin
        if (rd_v_r && RemW'(uns_r) >= rdata.rem) begin
          ov_nxt = 1'b1; okind_nxt = KIND_EXPIRED; oid_nxt = rdata.id;
          olast_nxt = 1'b1;
          ptr_nxt = LenW'(1);
          raddr = IdxW'(1);
          rd_v_nxt = (len_r > LenW'(1));
          state_nxt = ST_SYNC;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SYNC: begin
        if (!rd_v_r) begin
          len_nxt = len_r - 1'b1; uns_nxt = '0; state_nxt = ST_DONE;
        end else begin
          we = 1'b1; waddr = IdxW'(ptr_r - 1'b1);
          wdata.id = rdata.id;
          wdata.rem = (RemW'(uns_r) >= rdata.rem) ? '0 : rdata.rem - RemW'(uns_r);
          ptr_nxt = ptr_r + 1'b1;
          raddr = IdxW'(ptr_r + 1'b1);
          rd_v_nxt = (ptr_r + 1'b1 < len_r);
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; flush_r <= FlushReset; len_r <= '0; uns_r <= '0;
      tick_r <= '0; ov_r <= 1'b0; rd_v_r <= 1'b0; ptr_r <= '0;
    end else begin
      state_r <= state_nxt; len_r <= len_nxt; uns_r <= uns_nxt; tick_r <= tick_nxt;
      ov_r <= ov_nxt; rd_v_r <= rd_v_nxt; ptr_r <= ptr_nxt;
      if (cfg_we) begin
        flush_r <= cfg_wdata;
      end
    end
    id_r <= id_nxt; rem_r <= rem_nxt; hold_r <= hold_nxt;
    okind_r <= okind_nxt; olast_r <= olast_nxt; oid_r <= oid_nxt;
  end

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LenW'(MaxTimers)) else $error("queue length out of range");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ov_nxt |-> state_nxt != ST_IDLE) else $error("result issued while idle");
  a_sync_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SYNC && !rd_v_r) |=> uns_r == '0) else $error("unsynced not cleared");
endmodule
